/* rtl/mm_pkg.sv */
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types and constants for the fixed-point matrix multiply block.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int ELEM_W = 16;  // Q8.8 element
  localparam int PROD_W = 32;  // Q16.16 product element
  localparam int ACC_W  = 36;  // holds a sum of eight full-scale products
  localparam int DIM_W  = 4;   // dimension register width
  localparam int IDX_W  = 3;   // row and column index fields
  localparam int LIN_W  = 6;   // row * dim + col before trimming to the RAM address

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [ELEM_W-1:0] element;
  } mm_in_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] product;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic                     last;
  } mm_out_t;

  // Travels with each read pair through the MAC pipeline.
  typedef struct packed {
    logic             vld;
    logic             first;   // first term of a sum
    logic             fin;     // final term of a sum
    logic             lastel;  // belongs to the final element of the run
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mm_tag_t;

endpackage

/* rtl/matrix_multiply.sv */
// ----------------------------------------------------------------------------
// matrix_multiply
// Fixed-point matrix product C = A * B with APB-configured dimensions.
// ----------------------------------------------------------------------------
// A load transfer writes one Q8.8 element of A or B. A compute transfer
// streams out every element of C in row-major order. Each cycle in which the
// pipeline is not held by a stalled output performs one multiply-accumulate
// fed by one read of each element RAM.
// Input is stalled while a compute run is in flight; the last result may still
// sit in the output register when the next transfer is taken.
module matrix_multiply #(
  parameter int MAX_DIM = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mm_pkg::mm_in_t        in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mm_pkg::mm_out_t       out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import mm_pkg::*;

  localparam int AW = $clog2(MAX_DIM*MAX_DIM);

  logic [DIM_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic [DIM_W-1:0] dim_m, dim_n, dim_k;
  logic             cfg_wr;
  logic             in_acc, idx_ok, start, we_a, we_b;
  logic [LIN_W-1:0] wr_lin;
  logic [AW-1:0]    raddr_a, raddr_b;
  logic             issuing, adv, mac_busy, busy;
  mm_tag_t          tag1;
  logic [ELEM_W-1:0] a_rdata, b_rdata;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end
    if (v > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_W'(1);
      inner_dim_r <= DIM_W'(1);
      cols_b_r    <= DIM_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ROWS_A:    rows_a_r    <= pwdata[DIM_W-1:0];
        REG_INNER_DIM: inner_dim_r <= pwdata[DIM_W-1:0];
        REG_COLS_B:    cols_b_r    <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROWS_A:    prdata = 32'(rows_a_r);
      REG_INNER_DIM: prdata = 32'(inner_dim_r);
      REG_COLS_B:    prdata = 32'(cols_b_r);
      default:       prdata = '0;
    endcase
  end

  assign dim_m = clamp_dim(rows_a_r);
  assign dim_n = clamp_dim(inner_dim_r);
  assign dim_k = clamp_dim(cols_b_r);

  // Input decode.
  assign busy     = issuing || tag1.vld || mac_busy;
  assign in_stall = busy;
  assign in_acc   = in_valid && !in_stall;
  assign idx_ok   = ({1'b0, in_data.row} < DIM_W'(MAX_DIM)) &&
                    ({1'b0, in_data.col} < DIM_W'(MAX_DIM));
  assign wr_lin   = LIN_W'(in_data.row) * LIN_W'(MAX_DIM) + LIN_W'(in_data.col);

  always_comb begin
    we_a  = 1'b0;
    we_b  = 1'b0;
    start = 1'b0;
    unique case (in_data.opcode)
      OP_LOAD_A:  we_a  = in_acc && idx_ok;
      OP_LOAD_B:  we_b  = in_acc && idx_ok;
      OP_COMPUTE: start = in_acc;
      default: ;
    endcase
  end

  mm_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_DIM*MAX_DIM)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (wr_lin[AW-1:0]),
    .wdata (in_data.element),
    .re    (adv),
    .raddr (raddr_a),
    .rdata (a_rdata)
  );

  mm_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_DIM*MAX_DIM)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (wr_lin[AW-1:0]),
    .wdata (in_data.element),
    .re    (adv),
    .raddr (raddr_b),
    .rdata (b_rdata)
  );

  mm_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .adv     (adv),
    .dim_m   (dim_m),
    .dim_n   (dim_n),
    .dim_k   (dim_k),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .issuing (issuing),
    .tag1    (tag1)
  );

  mm_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .a_rdata   (a_rdata),
    .b_rdata   (b_rdata),
    .tag1      (tag1),
    .out_stall (out_stall),
    .adv       (adv),
    .busy      (mac_busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_no_load_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !(we_a || we_b || start))
    else $error("matrix_multiply: transfer taken while a compute run is active");
`endif

endmodule

/* rtl/mm_ram.sv */
// ----------------------------------------------------------------------------
// mm_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read that holds while the read enable is low.
// ----------------------------------------------------------------------------
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/mm_seq.sv */
// ----------------------------------------------------------------------------
// mm_seq
// Read sequencer: walks row, column and inner index and issues one read of
// each element store per cycle while the pipeline advances, with a tag that follows the read data.
// ----------------------------------------------------------------------------
module mm_seq #(
  parameter int MAX_DIM = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic                                  adv,
  input  logic [mm_pkg::DIM_W-1:0]              dim_m,
  input  logic [mm_pkg::DIM_W-1:0]              dim_n,
  input  logic [mm_pkg::DIM_W-1:0]              dim_k,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    raddr_a,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    raddr_b,
  output logic                                  issuing,
  output mm_pkg::mm_tag_t                       tag1
);
  import mm_pkg::*;

  localparam int IW = $clog2(MAX_DIM);
  localparam int AW = $clog2(MAX_DIM*MAX_DIM);

  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, l_r, l_nxt;
  logic          iss_r, iss_nxt;
  logic          l_last, j_last, i_last;
  logic [LIN_W-1:0] lin_a, lin_b;
  mm_tag_t       tag_iss, tag1_r;

  assign l_last = (DIM_W'(l_r) == dim_n - DIM_W'(1));
  assign j_last = (DIM_W'(j_r) == dim_k - DIM_W'(1));
  assign i_last = (DIM_W'(i_r) == dim_m - DIM_W'(1));

  always_comb begin
    i_nxt   = i_r;
    j_nxt   = j_r;
    l_nxt   = l_r;
    iss_nxt = iss_r;
    if (start) begin
      iss_nxt = 1'b1;
      i_nxt   = '0;
      j_nxt   = '0;
      l_nxt   = '0;
    end else if (iss_r && adv) begin
      if (l_last) begin
        l_nxt = '0;
        if (j_last) begin
          j_nxt = '0;
          if (i_last) begin
            iss_nxt = 1'b0;
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end else begin
          j_nxt = j_r + IW'(1);
        end
      end else begin
        l_nxt = l_r + IW'(1);
      end
    end
  end

  // A is read along row i, B down column j.
  assign lin_a   = LIN_W'(i_r) * LIN_W'(MAX_DIM) + LIN_W'(l_r);
  assign lin_b   = LIN_W'(l_r) * LIN_W'(MAX_DIM) + LIN_W'(j_r);
  assign raddr_a = lin_a[AW-1:0];
  assign raddr_b = lin_b[AW-1:0];

  always_comb begin
    tag_iss.vld    = iss_r;
    tag_iss.first  = (l_r == '0);
    tag_iss.fin    = l_last;
    tag_iss.lastel = i_last && j_last;
    tag_iss.row    = IDX_W'(i_r);
    tag_iss.col    = IDX_W'(j_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r  <= 1'b0;
      i_r    <= '0;
      j_r    <= '0;
      l_r    <= '0;
      tag1_r <= '0;
    end else begin
      iss_r <= iss_nxt;
      i_r   <= i_nxt;
      j_r   <= j_nxt;
      l_r   <= l_nxt;
      if (adv) begin
        tag1_r <= tag_iss;
      end
    end
  end

  assign issuing = iss_r;
  assign tag1    = tag1_r;

`ifndef SYNTHESIS
  a_issue_starts_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(iss_r) |-> $past(start))
    else $error("mm_seq: issue began without a compute start");

  a_issue_stops_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    iss_r && adv && l_last && j_last && i_last |=> !iss_r)
    else $error("mm_seq: issue continued past the final element");
`endif

endmodule

/* rtl/mm_mac.sv */
// ----------------------------------------------------------------------------
// mm_mac
// Multiply-accumulate datapath: registered product, running sum, saturation
// to Q16.16 and the result output register.
// ----------------------------------------------------------------------------
module mm_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [mm_pkg::ELEM_W-1:0]   a_rdata,
  input  logic signed [mm_pkg::ELEM_W-1:0]   b_rdata,
  input  mm_pkg::mm_tag_t                    tag1,
  input  logic                               out_stall,
  output logic                               adv,
  output logic                               busy,
  output logic                               out_valid,
  output mm_pkg::mm_out_t                    out_data
);
  import mm_pkg::*;

  localparam logic signed [PROD_W-1:0] SAT_MAX = {1'b0, {(PROD_W-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_MIN = {1'b1, {(PROD_W-1){1'b0}}};

  logic signed [PROD_W-1:0] p_r;
  mm_tag_t                  tag2_r;
  logic [ACC_W-1:0]         acc_r, acc_sum;
  logic                     ovf_hi, ovf_lo;
  logic signed [PROD_W-1:0] sat;
  logic                     out_valid_r;
  mm_out_t                  out_data_r;

  // The whole pipeline moves only when the output register can take a result.
  assign adv  = !out_valid_r || !out_stall;
  assign busy = tag2_r.vld;

  assign acc_sum = (tag2_r.first ? '0 : acc_r) + ACC_W'(p_r);
  assign ovf_hi  = !acc_sum[ACC_W-1] && (|acc_sum[ACC_W-2:PROD_W-1]);
  assign ovf_lo  = acc_sum[ACC_W-1] && !(&acc_sum[ACC_W-2:PROD_W-1]);

  always_comb begin
    if (ovf_hi) begin
      sat = SAT_MAX;
    end else if (ovf_lo) begin
      sat = SAT_MIN;
    end else begin
      sat = acc_sum[PROD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      tag2_r      <= tag1;
      out_valid_r <= tag2_r.vld && tag2_r.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r <= a_rdata * b_rdata;
      if (tag2_r.vld) begin
        acc_r <= acc_sum;
      end
      if (tag2_r.vld && tag2_r.fin) begin
        out_data_r.product <= sat;
        out_data_r.out_row <= tag2_r.row;
        out_data_r.out_col <= tag2_r.col;
        out_data_r.last    <= tag2_r.lastel;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_final_sum_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    adv && tag2_r.vld && tag2_r.fin |=> out_valid_r)
    else $error("mm_mac: completed sum did not reach the output register");

  a_last_follows_tag: assert property (@(posedge clk) disable iff (!rst_n)
    adv && tag2_r.vld && tag2_r.fin && tag2_r.lastel |=> out_data_r.last)
    else $error("mm_mac: final element not marked last");
`endif

endmodule
